// ===== rtl/core/xcr_pkg.sv =====
package xcr_pkg;

    // default payload length of one packet
    localparam int PACKET_BYTES_DEF = 128;

    // link symbols
    localparam logic [7:0] SYM_SOH = 8'h01;
    localparam logic [7:0] SYM_EOT = 8'h04;
    localparam logic [7:0] SYM_ACK = 8'h06;
    localparam logic [7:0] SYM_NAK = 8'h15;
    localparam logic [7:0] SUM_ONES = 8'hFF;

    // input operation codes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // receiver phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FIRST = 3'd1,
        PH_FRAME = 3'd2,
        PH_BLOCK = 3'd3,
        PH_COMPL = 3'd4,
        PH_DATA  = 3'd5,
        PH_CSUM  = 3'd6
    } phase_t;

    // one input word
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } item_t;

    // one result word
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [6:0]  data_offset;
        logic [7:0]  block_number;
        logic        packet_done;
        logic        packet_good;
        logic        transfer_done;
        logic        end_status;
        logic [7:0]  end_byte;
        logic [15:0] accepted_packets;
    } result_t;

endpackage

// ===== rtl/core/xcr_in_stage.sv =====
module xcr_in_stage
    import xcr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  down_ready,
    output logic  in_valid,
    output item_t in_item
);

    logic  valid_reg;
    item_t item_reg;

    // take a new word when empty or when the held one moves on
    assign s_ready  = !valid_reg || down_ready;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // payload holds no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/core/xcr_engine.sv =====
module xcr_engine
    import xcr_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    output result_t res
);

    localparam int IDX_W = $clog2(PACKET_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PACKET_BYTES);

    phase_t           phase_reg, phase_next;
    logic [7:0]       expected_block_reg, expected_block_next;
    logic [7:0]       header_block_reg, header_block_next;
    logic [7:0]       header_complement_reg, header_complement_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]      good_count_reg, good_count_next;

    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W+6:0] idx_wide;
    logic [8:0]       header_sum;
    logic             pkt_ok;

    assign idx_inc    = byte_index_reg + 1'b1;
    assign idx_wide   = {7'd0, byte_index_reg};
    assign header_sum = {1'b0, header_block_reg} + {1'b0, header_complement_reg};
    assign pkt_ok     = (running_sum_reg == item.rx_byte)
                     && (header_block_reg == expected_block_reg)
                     && (header_sum == {1'b0, SUM_ONES});

    // next state and result for the word in the input register
    always_comb begin
        phase_next             = phase_reg;
        expected_block_next    = expected_block_reg;
        header_block_next      = header_block_reg;
        header_complement_next = header_complement_reg;
        running_sum_next       = running_sum_reg;
        byte_index_next        = byte_index_reg;
        good_count_next        = good_count_reg;

        res = '0;

        unique case (item.opcode)
            OP_START: begin
                phase_next             = PH_FIRST;
                expected_block_next    = 8'd1;
                good_count_next        = 16'd0;
                header_block_next      = 8'd0;
                header_complement_next = 8'd0;
                running_sum_next       = 8'd0;
                byte_index_next        = '0;
                res.tx_valid           = 1'b1;
                res.tx_byte            = SYM_NAK;
            end
            OP_TIMEOUT: begin
                if (phase_reg == PH_FIRST) begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = SYM_NAK;
                end
            end
            OP_BYTE: begin
                unique case (phase_reg)
                    PH_FIRST, PH_FRAME: begin
                        if (item.rx_byte == SYM_SOH) begin
                            header_block_next      = 8'd0;
                            header_complement_next = 8'd0;
                            running_sum_next       = 8'd0;
                            byte_index_next        = '0;
                            phase_next             = PH_BLOCK;
                        end else if (item.rx_byte == SYM_EOT) begin
                            res.tx_valid      = 1'b1;
                            res.tx_byte       = SYM_ACK;
                            res.transfer_done = 1'b1;
                            phase_next        = PH_IDLE;
                        end else begin
                            res.transfer_done = 1'b1;
                            res.end_status    = 1'b1;
                            res.end_byte      = item.rx_byte;
                            phase_next        = PH_IDLE;
                        end
                    end
                    PH_BLOCK: begin
                        header_block_next = item.rx_byte;
                        phase_next        = PH_COMPL;
                    end
                    PH_COMPL: begin
                        header_complement_next = item.rx_byte;
                        phase_next             = PH_DATA;
                    end
                    PH_DATA: begin
                        res.data_valid   = 1'b1;
                        res.data_byte    = item.rx_byte;
                        res.data_offset  = idx_wide[6:0];
                        running_sum_next = running_sum_reg + item.rx_byte;
                        byte_index_next  = idx_inc;
                        if (idx_inc >= IDX_LAST) begin
                            phase_next = PH_CSUM;
                        end
                    end
                    PH_CSUM: begin
                        res.packet_done = 1'b1;
                        res.packet_good = pkt_ok;
                        res.tx_valid    = 1'b1;
                        if (pkt_ok) begin
                            res.tx_byte         = SYM_ACK;
                            expected_block_next = expected_block_reg + 8'd1;
                            if (good_count_reg != 16'hFFFF) begin
                                good_count_next = good_count_reg + 16'd1;
                            end
                        end else begin
                            res.tx_byte = SYM_NAK;
                        end
                        header_block_next      = 8'd0;
                        header_complement_next = 8'd0;
                        running_sum_next       = 8'd0;
                        byte_index_next        = '0;
                        phase_next             = PH_FRAME;
                    end
                    default: begin
                        // idle: no transfer running
                    end
                endcase
            end
            default: begin
                // unknown operation is ignored
            end
        endcase

        res.block_number     = expected_block_next;
        res.accepted_packets = good_count_next;
    end

    // state registers advance when a word moves to the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg             <= PH_IDLE;
            expected_block_reg    <= 8'd1;
            header_block_reg      <= 8'd0;
            header_complement_reg <= 8'd0;
            running_sum_reg       <= 8'd0;
            byte_index_reg        <= '0;
            good_count_reg        <= 16'd0;
        end else if (fire) begin
            phase_reg             <= phase_next;
            expected_block_reg    <= expected_block_next;
            header_block_reg      <= header_block_next;
            header_complement_reg <= header_complement_next;
            running_sum_reg       <= running_sum_next;
            byte_index_reg        <= byte_index_next;
            good_count_reg        <= good_count_next;
        end
    end

endmodule

// ===== rtl/core/xcr_out_stage.sv =====
module xcr_out_stage
    import xcr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  result_t res,
    output logic    up_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    // room when empty or when the held word is taken now
    assign up_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/core/xmodem_checksum_receiver_core.sv =====
// XMODEM checksum receiver. Each input word is a start command, a received
// serial byte or a timeout tick, and each one yields exactly one result word
// with the response byte to send (NAK or ACK), the tentative payload byte and
// its offset, packet and transfer end flags, the expected block number and a
// saturating count of good packets. Payload bytes of a packet that fails the
// checksum, block or complement check are still streamed and must be dropped
// by the user when packet_good comes back low. The block takes one word per
// clock while m_axis_tready stays high: a word waits in the input register,
// where the receiver state and the result are formed, and then sits in the
// output register. PACKET_BYTES sets the payload length.
module xmodem_checksum_receiver_core
    import xcr_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // rx_byte
    input  logic [1:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], data_byte[15:8], data_offset[22:16], block_number[30:23],
    // end_byte[38:31], accepted_packets[54:39], zero pad[55]
    output logic [55:0] m_axis_tdata,
    // tx_valid[0], data_valid[1], packet_done[2], packet_good[3],
    // transfer_done[4], end_status[5]
    output logic [5:0]  m_axis_tuser
);

    item_t   s_item, in_item;
    result_t eng_res, m_res;
    logic    in_valid, out_ready, fire;

    assign s_item.opcode  = s_axis_tuser;
    assign s_item.rx_byte = s_axis_tdata;

    // word moves from input register to output register
    assign fire = in_valid && out_ready;

    xcr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .down_ready (out_ready),
        .in_valid   (in_valid),
        .in_item    (in_item)
    );

    xcr_engine #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item),
        .res     (eng_res)
    );

    xcr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .res      (eng_res),
        .up_ready (out_ready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_res    (m_res)
    );

    // pack result word onto the master side
    assign m_axis_tdata = {1'b0,
                           m_res.accepted_packets,
                           m_res.end_byte,
                           m_res.block_number,
                           m_res.data_offset,
                           m_res.data_byte,
                           m_res.tx_byte};

    assign m_axis_tuser = {m_res.end_status,
                           m_res.transfer_done,
                           m_res.packet_good,
                           m_res.packet_done,
                           m_res.data_valid,
                           m_res.tx_valid};

endmodule
